// ===== hw/rtl/decimal_to_balanced_ternary_top_assert.svh =====
// assertion macros for the converter sequencer module
`ifndef DECIMAL_TO_BALANCED_TERNARY_TOP_ASSERT_SVH
`define DECIMAL_TO_BALANCED_TERNARY_TOP_ASSERT_SVH

`ifndef SYNTH
// consequent checked in the same cycle as the antecedent
`define DBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbt same-cycle check failed");
// consequent checked in the cycle after the antecedent
`define DBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbt next-cycle check failed");
`else
`define DBT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/dbt_pkg.sv =====
package dbt_pkg;

  // default sizes
  localparam int MAG_WIDTH_DEF = 31;
  localparam int MAX_TRITS_DEF = 21;

  // bits of the dividend consumed per divide-by-three step
  localparam int DIV_CHUNK = 8;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RADIX = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // trit codes
  localparam logic [1:0] TRIT_ZERO = 2'd0;
  localparam logic [1:0] TRIT_ONE  = 2'd1;
  localparam logic [1:0] TRIT_Z    = 2'd2;

  // ascii characters of interest
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic acc_char;
    logic conv_load;
    logic conv_step;
    logic conv_wb;
    logic set_over;
    logic rd_issue;
    logic out_load;
    logic cnt_dec;
    logic clear;
  } dbt_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic err_any;
    logic mag_zero;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic out_free;
  } dbt_sts_t;

endpackage

// ===== hw/rtl/dbt_if.sv =====
// character input channel
interface dbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// trit result channel
interface dbt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] trit;
  logic       last_result;

  modport source (output valid, output status, output trit, output last_result, input ready);
  modport sink (input valid, input status, input trit, input last_result, output ready);
endinterface

// ===== hw/rtl/dbt_datapath.sv =====
module dbt_datapath import dbt_pkg::*; #(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF,
  parameter int MAX_TRITS = MAX_TRITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  dbt_cmd_t   cmd,
  output dbt_sts_t   sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [1:0] out_trit,
  output logic       out_last
);

  localparam int CNT_W  = $clog2(MAX_TRITS + 1);
  localparam int ADDR_W = $clog2(MAX_TRITS);
  localparam int NCH    = (MAG_WIDTH + DIV_CHUNK) / DIV_CHUNK;
  localparam int DW     = NCH * DIV_CHUNK;

  logic [MAG_WIDTH-1:0] mag_r;
  logic                 neg_r;
  logic [1:0]           err_r;
  logic                 pm_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DW-1:0]        work_r;
  logic [1:0]           rem_r;
  logic [1:0]           trit_mem_r [MAX_TRITS];
  logic [1:0]           rd_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [1:0]           out_trit_r;
  logic                 out_last_r;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [MAG_WIDTH+3:0] prod;
  logic                 mag_ovf;
  logic                 radix_now;
  logic                 over_now;
  logic [1:0]           err_nxt;
  logic [MAG_WIDTH:0]   mag_inc;
  logic [DW-1:0]        work_nxt;
  logic [1:0]           rem_nxt;
  logic [1:0]           new_trit;
  logic [CNT_W-1:0]     cnt_less;
  logic [1:0]           trit_signed;

  // character classification and value*10+digit
  assign is_digit = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);
  assign digit    = char_code[3:0];
  assign prod     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
                  + {{MAG_WIDTH{1'b0}}, digit};
  assign mag_ovf  = |prod[MAG_WIDTH+3:MAG_WIDTH];

  // error detection, a radix error outranks overflow
  assign radix_now = (pm_r && !is_digit) || ((char_code == CHR_MINUS) && last_char)
                   || (!is_digit && (char_code != CHR_MINUS));
  assign over_now  = is_digit && (err_r != ST_OVER) && mag_ovf;
  assign err_nxt   = radix_now ? ST_RADIX :
                     (over_now && (err_r == ST_OK)) ? ST_OVER : err_r;

  // token registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      mag_r <= '0;
      neg_r <= 1'b0;
      err_r <= ST_OK;
      pm_r  <= 1'b0;
    end else begin
      if (cmd.acc_char) begin
        pm_r  <= !last_char && (char_code == CHR_MINUS);
        err_r <= err_nxt;
        if (pm_r && is_digit) begin
          neg_r <= 1'b1;
        end
        if (is_digit && (err_r != ST_OVER) && !mag_ovf) begin
          mag_r <= prod[MAG_WIDTH-1:0];
        end
      end
      if (cmd.set_over) begin
        err_r <= ST_OVER;
      end
      if (cmd.conv_wb) begin
        mag_r <= work_nxt[MAG_WIDTH-1:0];
      end
    end
  end

  // divide (m+1) by three, one chunk of bits per cycle, msb first
  assign mag_inc = {1'b0, mag_r} + {{MAG_WIDTH{1'b0}}, 1'b1};

  always_comb begin
    logic [2:0]           part;
    logic [1:0]           r;
    logic [DIV_CHUNK-1:0] q;
    r    = rem_r;
    q    = '0;
    part = '0;
    for (int k = 0; k < DIV_CHUNK; k++) begin
      part = {r, work_r[DW-1-k]};
      if (part >= 3'd3) begin
        r = 2'(part - 3'd3);
        q[DIV_CHUNK-1-k] = 1'b1;
      end else begin
        r = part[1:0];
      end
    end
    rem_nxt  = r;
    work_nxt = (work_r << DIV_CHUNK) | DW'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_load) begin
      work_r <= DW'(mag_inc);
      rem_r  <= 2'd0;
    end else if (cmd.conv_step) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // (m+1) mod 3 of 0, 1, 2 means m mod 3 of 2, 0, 1
  always_comb begin
    case (rem_nxt)
      2'd0:    new_trit = TRIT_Z;
      2'd1:    new_trit = TRIT_ZERO;
      default: new_trit = TRIT_ONE;
    endcase
  end

  // trit count, also the read pointer while sending
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.conv_wb) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_less;
    end
  end

  assign cnt_less = cnt_r - 1'b1;

  // trit buffer, least significant trit at the lowest address
  always_ff @(posedge clk) begin
    if (cmd.conv_wb) begin
      trit_mem_r[cnt_r[ADDR_W-1:0]] <= new_trit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_r <= trit_mem_r[cnt_less[ADDR_W-1:0]];
    end
  end

  // swap one and minus one for a negative number
  always_comb begin
    case (rd_r)
      TRIT_ONE: trit_signed = neg_r ? TRIT_Z : TRIT_ONE;
      TRIT_Z:   trit_signed = neg_r ? TRIT_ONE : TRIT_Z;
      default:  trit_signed = rd_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= err_r;
      out_trit_r   <= (sts.err_any || sts.cnt_zero) ? TRIT_ZERO : trit_signed;
      out_last_r   <= sts.err_any || sts.cnt_zero || sts.cnt_one;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_trit   = out_trit_r;
  assign out_last   = out_last_r;

  // status to the sequencer
  assign sts.err_any  = (err_r != ST_OK);
  assign sts.mag_zero = (mag_r == '0);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_one  = (cnt_r == CNT_W'(1));
  assign sts.cnt_full = (cnt_r == CNT_W'(MAX_TRITS));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== hw/rtl/dbt_ctrl.sv =====
`include "decimal_to_balanced_ternary_top_assert.svh"

module dbt_ctrl import dbt_pkg::*; #(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dbt_sts_t sts,
  output dbt_cmd_t cmd
);

  localparam int NCH  = (MAG_WIDTH + DIV_CHUNK) / DIV_CHUNK;
  localparam int CH_W = $clog2(NCH) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  logic [CH_W-1:0] chunk_r;
  logic [CH_W-1:0] chunk_nxt;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_char = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.err_any) begin
          state_nxt = S_SEND;
        end else if (sts.mag_zero) begin
          state_nxt = sts.cnt_zero ? S_SEND : S_READ;
        end else if (sts.cnt_full) begin
          cmd.set_over = 1'b1;
          state_nxt    = S_SEND;
        end else begin
          cmd.conv_load = 1'b1;
          chunk_nxt     = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.conv_step = 1'b1;
        if (chunk_r == CH_W'(NCH - 1)) begin
          cmd.conv_wb = 1'b1;
          state_nxt   = S_CHECK;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_SEND;
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.err_any || sts.cnt_zero || sts.cnt_one) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  // a character that is not the last one keeps the block idle
  `DBT_ASSERT_NEXT(a_mid_char_stays_idle, clk, rst_n, in_valid && in_ready && !in_last, state_r == S_IDLE)
  // the last character always starts the conversion check
  `DBT_ASSERT_NEXT(a_last_char_checks, clk, rst_n, in_valid && in_ready && in_last, state_r == S_CHECK)
  // the chunk counter never runs past the dividend
  `DBT_ASSERT_SAME(a_chunk_in_range, clk, rst_n, state_r == S_DIV, chunk_r <= CH_W'(NCH - 1))
  // a buffer read only happens with trits stored
  `DBT_ASSERT_SAME(a_read_has_trit, clk, rst_n, state_r == S_READ, !sts.cnt_zero && !sts.err_any)

endmodule

// ===== hw/rtl/decimal_to_balanced_ternary_top.sv =====
// channel   direction  payload                          transfer when
// in_ch     in         char_code[7:0], last_char        valid && ready
// out_ch    out        status[1:0], trit[1:0], last_res  valid && ready
//
// a character that is not the last keeps the block idle; ready is high only when idle.
// the last character leads to the check state, then each trit to a divide pass over
// NCH = (MAG_WIDTH + 8) / 8 chunks of the shared divide-by-three unit (4 by default).
// each trit result then takes a buffer read and an output load, an error or zero
// result just the load, stalled by out_ch; the output register lets the next token in.
// reset is synchronous, active low; no clearing pass is needed.
module decimal_to_balanced_ternary_top import dbt_pkg::*; #(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF,
  parameter int MAX_TRITS = MAX_TRITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dbt_in_if.sink   in_ch,
  dbt_out_if.source out_ch
);

  dbt_cmd_t cmd;
  dbt_sts_t sts;

  // sequencer
  dbt_ctrl #(
    .MAG_WIDTH (MAG_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_char),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // accumulator, divider, trit buffer and output register
  dbt_datapath #(
    .MAG_WIDTH (MAG_WIDTH),
    .MAX_TRITS (MAX_TRITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_code  (in_ch.char_code),
    .last_char  (in_ch.last_char),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_trit   (out_ch.trit),
    .out_last   (out_ch.last_result)
  );

endmodule
